[rtl/skn_pkg.sv]
// Shared types, constants and byte/cell functions for the SKINNY-128-384 core.
package skn_pkg;

    localparam int ROUND_COUNT_DEF = 56;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int BLK_W           = 128;
    localparam int HALF_W          = 64;
    localparam int RC_W            = 6;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TK2_LO = 3'd0,
        CFG_TK2_HI = 3'd1,
        CFG_TK3_LO = 3'd2,
        CFG_TK3_HI = 3'd3,
        CFG_MARKER = 3'd4
    } t_cfg_idx;

    // Sequencer states of the round engine
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_RUN,
        SEQ_DONE
    } t_seq_state;

    localparam logic [31:0] MARKER_BIT  = 32'h0002_0000;
    localparam logic [31:0] ROW2_CONST  = 32'h0000_0002;
    localparam logic [31:0] LFSR2_SHIFT = 32'hFEFE_FEFE;
    localparam logic [31:0] LFSR2_FB    = 32'h0101_0101;
    localparam logic [31:0] LFSR3_SHIFT = 32'h7F7F_7F7F;
    localparam logic [31:0] LFSR3_FB    = 32'h8080_8080;

    // Cell map: new cell i takes old cell map[i]
    typedef logic [15:0][3:0] t_cell_map;

    localparam t_cell_map CELL_PERM = {
        4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0,
        4'd11, 4'd12, 4'd14, 4'd10, 4'd13, 4'd8, 4'd15, 4'd9
    };

    // Cell map of n successive permutations (elaboration only)
    function automatic t_cell_map cell_map_pow(input int n);
        t_cell_map m;
        t_cell_map t;
        for (int i = 0; i < 16; i++) m[i] = 4'(i);
        t = m;
        for (int k = 0; k < n; k++) begin
            for (int i = 0; i < 16; i++) t[i] = m[CELL_PERM[i]];
            m = t;
        end
        return m;
    endfunction

    function automatic t_cell_map cell_map_inv(input t_cell_map m);
        t_cell_map t;
        t = '0;
        for (int i = 0; i < 16; i++) t[m[i]] = 4'(i);
        return t;
    endfunction

    // Byte routing of a 128-bit block by a constant cell map
    function automatic logic [BLK_W-1:0] apply_cells(input logic [BLK_W-1:0] x,
                                                     input t_cell_map m);
        logic [BLK_W-1:0] y;
        y = '0;
        for (int i = 0; i < 16; i++) y[8*i +: 8] = x[{m[i], 3'b000} +: 8];
        return y;
    endfunction

    // S-box building blocks
    function automatic logic [7:0] sb_mix(input logic [7:0] x);
        return x ^ {3'b000, ~(x[7] | x[6]), 3'b000, ~(x[3] | x[2])};
    endfunction

    function automatic logic [7:0] sb_perm(input logic [7:0] x);
        return {x[2], x[1], x[7], x[6], x[4], x[0], x[3], x[5]};
    endfunction

    function automatic logic [7:0] sb_iperm(input logic [7:0] x);
        return {x[5], x[4], x[0], x[3], x[1], x[7], x[6], x[2]};
    endfunction

    function automatic logic [7:0] sb_swap(input logic [7:0] x);
        return {x[7:3], x[1], x[2], x[0]};
    endfunction

    function automatic logic [7:0] sbox_fwd(input logic [7:0] v);
        logic [7:0] x;
        x = sb_mix(v);
        x = sb_mix(sb_perm(x));
        x = sb_mix(sb_perm(x));
        x = sb_mix(sb_perm(x));
        return sb_swap(x);
    endfunction

    function automatic logic [7:0] sbox_inv(input logic [7:0] v);
        logic [7:0] x;
        x = sb_mix(sb_swap(v));
        x = sb_mix(sb_iperm(x));
        x = sb_mix(sb_iperm(x));
        x = sb_mix(sb_iperm(x));
        return x;
    endfunction

    function automatic logic [BLK_W-1:0] sub_block(input logic [BLK_W-1:0] x,
                                                   input logic inv);
        logic [BLK_W-1:0] y;
        y = '0;
        for (int i = 0; i < 16; i++)
            y[8*i +: 8] = inv ? sbox_inv(x[8*i +: 8]) : sbox_fwd(x[8*i +: 8]);
        return y;
    endfunction

    // Tweakey LFSRs, four bytes at a time
    function automatic logic [31:0] lfsr2(input logic [31:0] x);
        return ((x << 1) & LFSR2_SHIFT) ^ (((x >> 7) ^ (x >> 5)) & LFSR2_FB);
    endfunction

    function automatic logic [31:0] lfsr3(input logic [31:0] x);
        return ((x >> 1) & LFSR3_SHIFT) ^ (((x << 7) ^ (x << 1)) & LFSR3_FB);
    endfunction

    // 6-bit round constant LFSR
    function automatic logic [RC_W-1:0] rc_next(input logic [RC_W-1:0] rc);
        return {rc[RC_W-2:0], 1'b0} ^ {{(RC_W-1){1'b0}}, rc[5] ^ rc[4] ^ 1'b1};
    endfunction

endpackage

[rtl/skn_req_if.sv]
// Request channel: operation, block and tweak per beat.
interface skn_req_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [skn_pkg::HALF_W-1:0]    block_lo;
    logic [skn_pkg::HALF_W-1:0]    block_hi;
    logic [skn_pkg::HALF_W-1:0]    tweak_lo;
    logic [skn_pkg::HALF_W-1:0]    tweak_hi;

    modport source (
        output valid, func, block_lo, block_hi, tweak_lo, tweak_hi,
        input  ready
    );

    modport sink (
        input  valid, func, block_lo, block_hi, tweak_lo, tweak_hi,
        output ready
    );
endinterface

[rtl/skn_rsp_if.sv]
// Response channel: one output block per beat.
interface skn_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [skn_pkg::HALF_W-1:0]    result_lo;
    logic [skn_pkg::HALF_W-1:0]    result_hi;

    modport source (
        output valid, result_lo, result_hi,
        input  ready
    );

    modport sink (
        input  valid, result_lo, result_hi,
        output ready
    );
endinterface

[rtl/skn_round.sv]
// One SKINNY-128-384 round, forward or inverse, shared by all rounds.
module skn_round (
    input  logic [skn_pkg::BLK_W-1:0]  i_state,
    input  logic [skn_pkg::HALF_W-1:0] i_key,
    input  logic                       i_dec,
    output logic [skn_pkg::BLK_W-1:0]  o_state
);
    import skn_pkg::*;

    logic [BLK_W-1:0] sb;
    logic [31:0] e0, e1, e2, e3, er1, er2, er3, em1, em2, et;
    logic [31:0] d0, d1, d2, d3, a0, a1, a2, a3;
    logic [BLK_W-1:0] enc_out, dec_pre, dec_out;

    // Forward round: S-box, key add, shift rows, mix columns
    always_comb begin
        sb      = sub_block(i_state, 1'b0);
        e0      = sb[31:0] ^ i_key[31:0];
        e1      = sb[63:32] ^ i_key[63:32];
        e2      = sb[95:64] ^ ROW2_CONST;
        e3      = sb[127:96];
        er1     = {e1[23:0], e1[31:24]};
        er2     = {e2[15:0], e2[31:16]};
        er3     = {e3[7:0], e3[31:8]};
        em1     = er1 ^ er2;
        em2     = er2 ^ e0;
        et      = er3 ^ em2;
        enc_out = {em2, em1, e0, et};
    end

    // Inverse round: unmix, unshift, key add, inverse S-box
    always_comb begin
        d0      = i_state[31:0];
        d1      = i_state[63:32];
        d2      = i_state[95:64];
        d3      = i_state[127:96];
        a0      = d1;
        a2      = d3 ^ d1;
        a1      = d2 ^ a2;
        a3      = d0 ^ d3;
        dec_pre = {{a3[23:0], a3[31:24]},
                   {a2[15:0], a2[31:16]} ^ ROW2_CONST,
                   {a1[7:0], a1[31:8]} ^ i_key[63:32],
                   a0 ^ i_key[31:0]};
        dec_out = sub_block(dec_pre, 1'b1);
    end

    assign o_state = i_dec ? dec_out : enc_out;

endmodule

[rtl/skn_key_sched.sv]
// Key registers and the TK2/TK3 round key table, rebuilt one row per cycle.
module skn_key_sched #(
    parameter int ROUND_COUNT = skn_pkg::ROUND_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [skn_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [skn_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [$clog2(ROUND_COUNT)-1:0] i_rd_addr,
    output logic [skn_pkg::HALF_W-1:0]     o_rd_key,
    output logic                           o_busy
);
    import skn_pkg::*;

    localparam int ADDR_W = $clog2(ROUND_COUNT);
    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(ROUND_COUNT - 1);

    logic [BLK_W-1:0]  r_tk2, r_tk3;
    logic              r_marker;
    logic              r_load, r_building;
    logic [BLK_W-1:0]  r_a, r_b;
    logic [RC_W-1:0]   r_rc;
    logic [ADDR_W-1:0] r_cnt;
    logic [HALF_W-1:0] r_mem [ROUND_COUNT];
    logic [HALF_W-1:0] r_rd_key;

    logic              cfg_hit;
    logic              build_we;
    logic [BLK_W-1:0]  src_a, src_b, perm_a, perm_b, n_a, n_b;
    logic [RC_W-1:0]   src_rc, n_rc;
    logic [ADDR_W-1:0] src_idx;
    logic [31:0]       w0, w1;

    assign cfg_hit = i_cfg_we && (i_cfg_idx <= CFG_MARKER);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tk2    <= '0;
            r_tk3    <= '0;
            r_marker <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TK2_LO: r_tk2[63:0]   <= i_cfg_data;
                CFG_TK2_HI: r_tk2[127:64] <= i_cfg_data;
                CFG_TK3_LO: r_tk3[63:0]   <= i_cfg_data;
                CFG_TK3_HI: r_tk3[127:64] <= i_cfg_data;
                CFG_MARKER: r_marker      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Schedule step: first row starts from the key registers
    always_comb begin
        build_we = r_load | r_building;
        src_a    = r_load ? r_tk2 : r_a;
        src_b    = r_load ? r_tk3 : r_b;
        src_rc   = r_load ? '0 : r_rc;
        src_idx  = r_load ? '0 : r_cnt;
        n_rc     = rc_next(src_rc);
        w0       = src_a[31:0] ^ src_b[31:0] ^ {28'd0, n_rc[3:0]}
                   ^ (r_marker ? MARKER_BIT : 32'd0);
        w1       = src_a[63:32] ^ src_b[63:32] ^ {30'd0, n_rc[5:4]};
        perm_a   = apply_cells(src_a, CELL_PERM);
        perm_b   = apply_cells(src_b, CELL_PERM);
        n_a      = {perm_a[127:64], lfsr2(perm_a[63:32]), lfsr2(perm_a[31:0])};
        n_b      = {perm_b[127:64], lfsr3(perm_b[63:32]), lfsr3(perm_b[31:0])};
    end

    // Build control: reset and every accepted write restart the sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load     <= 1'b1;
            r_building <= 1'b0;
        end else begin
            r_load     <= cfg_hit;
            r_building <= build_we && (src_idx != LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (build_we) begin
            r_a   <= n_a;
            r_b   <= n_b;
            r_rc  <= n_rc;
            r_cnt <= src_idx + ADDR_W'(1);
        end
    end

    // Round key table
    always_ff @(posedge i_clk) begin
        if (build_we) r_mem[src_idx] <= {w1, w0};
        r_rd_key <= r_mem[i_rd_addr];
    end

    assign o_rd_key = r_rd_key;
    assign o_busy   = build_we;

endmodule

[rtl/skinny128_384_tweakable_block_cipher.sv]
// SKINNY-128-384 tweakable block cipher top level: sequencer, round engine, output register.
//
//   channel   dir  handshake          payload
//   i_req     in   valid/ready        func, block_lo/hi, tweak_lo/hi
//   o_rsp     out  valid/ready        result_lo/hi
//   i_cfg     in   i_cfg_we           i_cfg_idx, i_cfg_data (no read-back)
//
// A block is taken in the accept cycle, then passes through every round in turn
// in the single shared round unit, and then moves into the output register.
// The round key table is swept one row per cycle after reset and after every write
// to a key or marker register, during which i_req.ready stays low.
// The output register frees the round engine, so a new beat is taken while a
// result waits; a stalled result holds the next one in the finish state.
module skinny128_384_tweakable_block_cipher #(
    parameter int ROUND_COUNT = skn_pkg::ROUND_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    skn_req_if.sink                        i_req,
    skn_rsp_if.source                      o_rsp,
    input  logic                           i_cfg_we,
    input  logic [skn_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [skn_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import skn_pkg::*;

    localparam int ADDR_W = $clog2(ROUND_COUNT);
    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(ROUND_COUNT - 1);
    localparam t_cell_map FF_MAP  = cell_map_pow(ROUND_COUNT - 1);
    localparam t_cell_map INV_MAP = cell_map_inv(CELL_PERM);

    t_seq_state        r_seq, n_seq;
    logic [BLK_W-1:0]  r_blk, r_tk, r_res;
    logic              r_dec;
    logic [ADDR_W-1:0] r_cnt;
    logic              r_out_valid;

    logic              busy;
    logic              in_ready, accept, out_free, last_rnd, load_out;
    logic [ADDR_W-1:0] rd_addr;
    logic [HALF_W-1:0] tbl_key, rnd_key;
    logic [BLK_W-1:0]  rnd_out, tweak_in;

    skn_key_sched #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_key_sched (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rd_addr  (rd_addr),
        .o_rd_key   (tbl_key),
        .o_busy     (busy)
    );

    assign rnd_key = tbl_key ^ r_tk[63:0];

    skn_round u_round (
        .i_state (r_blk),
        .i_key   (rnd_key),
        .i_dec   (r_dec),
        .o_state (rnd_out)
    );

    assign tweak_in = {i_req.tweak_hi, i_req.tweak_lo};
    assign out_free = !r_out_valid || o_rsp.ready;
    assign last_rnd = (r_cnt == LAST);

    // Next state, handshake and table read address
    always_comb begin
        n_seq    = r_seq;
        in_ready = 1'b0;
        load_out = 1'b0;
        rd_addr  = '0;
        unique case (r_seq)
            SEQ_IDLE: begin
                in_ready = !busy;
                rd_addr  = i_req.func ? LAST : '0;
                if (i_req.valid && !busy) n_seq = SEQ_RUN;
            end
            SEQ_RUN: begin
                rd_addr = r_dec ? (LAST - r_cnt - ADDR_W'(1)) : (r_cnt + ADDR_W'(1));
                if (last_rnd) n_seq = SEQ_DONE;
            end
            SEQ_DONE: begin
                load_out = out_free;
                if (out_free) n_seq = SEQ_IDLE;
            end
            default: n_seq = SEQ_IDLE;
        endcase
    end

    assign accept      = i_req.valid && in_ready;
    assign i_req.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_seq <= SEQ_IDLE;
        else          r_seq <= n_seq;
    end

    // Block state, tweak cells and round count
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_blk <= {i_req.block_hi, i_req.block_lo};
            r_tk  <= i_req.func ? apply_cells(tweak_in, FF_MAP) : tweak_in;
            r_dec <= i_req.func;
            r_cnt <= '0;
        end else if (r_seq == SEQ_RUN) begin
            r_blk <= rnd_out;
            r_tk  <= r_dec ? apply_cells(r_tk, INV_MAP) : apply_cells(r_tk, CELL_PERM);
            r_cnt <= r_cnt + ADDR_W'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)         r_out_valid <= 1'b0;
        else if (load_out)    r_out_valid <= 1'b1;
        else if (o_rsp.ready) r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (load_out) r_res <= r_blk;
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.result_lo = r_res[63:0];
    assign o_rsp.result_hi = r_res[127:64];

endmodule

[tb/tb.sv]
// Self-checking testbench for the SKINNY-128-384 tweakable block cipher core.
`timescale 1ns / 100ps

module tb;
    import skn_pkg::*;

    localparam int          CLK_PERIOD    = 8;
    localparam int          NR            = ROUND_COUNT_DEF;
    localparam int          NUM_DIRECTED  = 12;
    localparam int          NUM_PHASES    = 8;
    localparam int          PHASE_BEATS   = 250;
    localparam int          HOLD_CYCLES   = 500;
    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          MAX_REPORTS   = 10;
    localparam logic        FUNC_ENC      = 1'b0;
    localparam logic        FUNC_DEC      = 1'b1;
    localparam logic [31:0] TWEAK_MARKER  = 32'h0002_0000;
    localparam logic [31:0] ROW2_RC       = 32'h0000_0002;
    localparam logic [63:0] ZERO64        = 64'h0;
    localparam logic [63:0] ONES64        = '1;
    localparam logic [63:0] ALT_A         = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [63:0] ALT_5         = 64'h5555_5555_5555_5555;
    localparam logic [63:0] LSB64         = 64'h0000_0000_0000_0001;
    localparam logic [63:0] MSB64         = 64'h8000_0000_0000_0000;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST = '1;

    // New cell i takes old cell CELL_ORDER[i]
    localparam logic [0:15][3:0] CELL_ORDER = {
        4'd9, 4'd15, 4'd8, 4'd13, 4'd10, 4'd14, 4'd12, 4'd11,
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7
    };

    typedef struct packed {
        logic        func;
        logic [63:0] block_lo;
        logic [63:0] block_hi;
        logic [63:0] tweak_lo;
        logic [63:0] tweak_hi;
    } t_cipher_req;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    skn_req_if req_bus();
    skn_rsp_if rsp_bus();

    skinny128_384_tweakable_block_cipher i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Mirror of the key registers and the precomputed round key rows
    logic [63:0] key2_lo, key2_hi, key3_lo, key3_hi;
    logic        marker_on;
    logic [63:0] round_keys [NR];
    logic [7:0]  sbox_enc [256];
    logic [7:0]  sbox_dec [256];

    logic [127:0] pending_blocks [$];
    int           mismatch_count = 0;

    // Idle control shared by sender and receiver
    bit idling_on = 1'b1;
    bit hold_req  = 1'b0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    t_cipher_req directed_reqs [NUM_DIRECTED] = '{
        '{FUNC_ENC, ZERO64, ZERO64, ZERO64, ZERO64},
        '{FUNC_DEC, ZERO64, ZERO64, ZERO64, ZERO64},
        '{FUNC_ENC, ONES64, ONES64, ONES64, ONES64},
        '{FUNC_DEC, ONES64, ONES64, ONES64, ONES64},
        '{FUNC_ENC, ONES64, ONES64, ZERO64, ZERO64},
        '{FUNC_DEC, ZERO64, ZERO64, ONES64, ONES64},
        '{FUNC_ENC, LSB64,  ZERO64, ZERO64, ZERO64},
        '{FUNC_ENC, ZERO64, MSB64,  ZERO64, ZERO64},
        '{FUNC_DEC, ZERO64, ZERO64, LSB64,  ZERO64},
        '{FUNC_DEC, ZERO64, ZERO64, ZERO64, MSB64},
        '{FUNC_ENC, ALT_5,  ALT_A,  ALT_5,  ALT_A},
        '{FUNC_DEC, ALT_A,  ALT_5,  ALT_A,  ALT_5}
    };

    // S-box layers, byte-wise
    function automatic logic [7:0] nl_layer(input logic [7:0] x);
        return x ^ (~(((x >> 1) | x) >> 2) & 8'h11);
    endfunction

    function automatic logic [7:0] wire_bits(input logic [7:0] x);
        return ((x & 8'h01) << 2) | ((x & 8'h06) << 5) | ((x & 8'h20) >> 5) |
               ((x & 8'hC8) >> 2) | ((x & 8'h10) >> 1);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w, input logic inv);
        logic [31:0] y;
        for (int i = 0; i < 4; i++)
            y[8*i +: 8] = inv ? sbox_dec[w[8*i +: 8]] : sbox_enc[w[8*i +: 8]];
        return y;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [127:0] shuffle_cells(input logic [127:0] x);
        logic [127:0] y;
        for (int i = 0; i < 16; i++) y[8*i +: 8] = x[8*CELL_ORDER[i] +: 8];
        return y;
    endfunction

    function automatic logic [31:0] tk2_lfsr(input logic [31:0] x);
        return ((x << 1) & 32'hFEFE_FEFE) ^ (((x >> 7) ^ (x >> 5)) & 32'h0101_0101);
    endfunction

    function automatic logic [31:0] tk3_lfsr(input logic [31:0] x);
        return ((x >> 1) & 32'h7F7F_7F7F) ^ (((x << 7) ^ (x << 1)) & 32'h8080_8080);
    endfunction

    // TK2/TK3 rows plus round constant (and marker) for every round
    function automatic void expand_round_keys();
        logic [127:0] a, b;
        logic [5:0]   rc;
        logic [31:0]  w0, w1;
        a  = {key2_hi, key2_lo};
        b  = {key3_hi, key3_lo};
        rc = '0;
        for (int r = 0; r < NR; r++) begin
            rc = (rc << 1) ^ (rc >> 5) ^ ((rc >> 4) & 6'd1) ^ 6'd1;
            w0 = a[31:0] ^ b[31:0] ^ {28'd0, rc[3:0]};
            w1 = a[63:32] ^ b[63:32] ^ {30'd0, rc[5:4]};
            if (marker_on) w0 ^= TWEAK_MARKER;
            round_keys[r] = {w1, w0};
            a = shuffle_cells(a);
            b = shuffle_cells(b);
            a[31:0]  = tk2_lfsr(a[31:0]);
            a[63:32] = tk2_lfsr(a[63:32]);
            b[31:0]  = tk3_lfsr(b[31:0]);
            b[63:32] = tk3_lfsr(b[63:32]);
        end
    endfunction

    // Full 56-round encryption or decryption of one block
    function automatic logic [127:0] cipher_block(input logic dec, input logic [127:0] blk,
                                                  input logic [127:0] twk);
        logic [31:0]  s0, s1, s2, s3, tmp;
        logic [63:0]  tk1_rows [NR];
        logic [127:0] t;
        t = twk;
        for (int r = 0; r < NR; r++) begin
            tk1_rows[r] = t[63:0];
            t = shuffle_cells(t);
        end
        {s3, s2, s1, s0} = blk;
        if (dec == FUNC_ENC) begin
            for (int r = 0; r < NR; r++) begin
                s0 = sub_word(s0, 1'b0);
                s1 = sub_word(s1, 1'b0);
                s2 = sub_word(s2, 1'b0);
                s3 = sub_word(s3, 1'b0);
                s0 ^= round_keys[r][31:0] ^ tk1_rows[r][31:0];
                s1 ^= round_keys[r][63:32] ^ tk1_rows[r][63:32];
                s2 ^= ROW2_RC;
                s1 = rotl32(s1, 8);
                s2 = rotl32(s2, 16);
                s3 = rotl32(s3, 24);
                s1 ^= s2;
                s2 ^= s0;
                tmp = s3 ^ s2;
                s3 = s2;
                s2 = s1;
                s1 = s0;
                s0 = tmp;
            end
        end else begin
            for (int r = NR - 1; r >= 0; r--) begin
                tmp = s3;
                s3 = s0;
                s0 = s1;
                s1 = s2;
                s3 ^= tmp;
                s2 = tmp ^ s0;
                s1 ^= s2;
                s1 = rotl32(s1, 24);
                s2 = rotl32(s2, 16);
                s3 = rotl32(s3, 8);
                s0 ^= round_keys[r][31:0] ^ tk1_rows[r][31:0];
                s1 ^= round_keys[r][63:32] ^ tk1_rows[r][63:32];
                s2 ^= ROW2_RC;
                s0 = sub_word(s0, 1'b1);
                s1 = sub_word(s1, 1'b1);
                s2 = sub_word(s2, 1'b1);
                s3 = sub_word(s3, 1'b1);
            end
        end
        return {s3, s2, s1, s0};
    endfunction

    // Random 64-bit word, biased toward the extremes
    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return ZERO64;
            1:       return ONES64;
            2:       return LSB64 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    endtask

    // S-box tables
    initial begin
        logic [7:0] x;
        for (int v = 0; v < 256; v++) begin
            x = nl_layer(8'(v));
            x = nl_layer(wire_bits(x));
            x = nl_layer(wire_bits(x));
            x = nl_layer(wire_bits(x));
            x = (x & 8'hF9) | ((x >> 1) & 8'h02) | ((x << 1) & 8'h04);
            sbox_enc[v] = x;
            sbox_dec[x] = 8'(v);
        end
    end

    // Register mirror; the row table is rebuilt at reset and on every write
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key2_lo   = '0;
            key2_hi   = '0;
            key3_lo   = '0;
            key3_hi   = '0;
            marker_on = 1'b0;
            expand_round_keys();
        end else if (cfg_we) begin
            case (cfg_idx)
                CFG_TK2_LO: key2_lo = cfg_data;
                CFG_TK2_HI: key2_hi = cfg_data;
                CFG_TK3_LO: key3_lo = cfg_data;
                CFG_TK3_HI: key3_hi = cfg_data;
                CFG_MARKER: marker_on = cfg_data[0];
                default: ;
            endcase
            expand_round_keys();
        end
    end

    // Check result beats against the oldest expectation, then predict new request beats
    always @(posedge i_clk) begin
        logic [127:0] want;
        if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_blocks.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result %h_%h", $time,
                             rsp_bus.result_hi, rsp_bus.result_lo);
            end else begin
                want = pending_blocks.pop_front();
                if (rsp_bus.result_lo !== want[63:0])
                    note_mismatch("result_lo", want[63:0], rsp_bus.result_lo);
                if (rsp_bus.result_hi !== want[127:64])
                    note_mismatch("result_hi", want[127:64], rsp_bus.result_hi);
            end
        end
        if (req_bus.valid && req_bus.ready)
            pending_blocks.push_back(cipher_block(req_bus.func,
                                                  {req_bus.block_hi, req_bus.block_lo},
                                                  {req_bus.tweak_hi, req_bus.tweak_lo}));
    end

    // Idle profile: bursts of varying density, with quiet stretches
    initial begin
        forever begin
            repeat (64) @(posedge i_clk);
            case ($urandom_range(0, 2))
                0:       send_idle_pct = 0;
                1:       send_idle_pct = 15;
                default: send_idle_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0:       recv_idle_pct = 0;
                1:       recv_idle_pct = 15;
                default: recv_idle_pct = 40;
            endcase
        end
    end

    // Result receiver: random stalls plus an occasional long hold-off
    initial begin
        int stall_left;
        int hold_left;
        rsp_bus.ready = 1'b0;
        stall_left    = 0;
        hold_left     = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
                if (idling_on && $urandom_range(0, 99) < recv_idle_pct)
                    stall_left = $urandom_range(1, 7);
            end
        end
    end

    // Watchdog
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("** skinny128_384_tweakable_block_cipher: FAILED **");
        $finish;
    end

    // Offer one request beat, with an optional gap, and wait for its handshake
    task automatic send_req(input t_cipher_req rq);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 7);
        if (gap > 0) begin
            @(negedge i_clk);
            req_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_bus.valid    <= 1'b1;
        req_bus.func     <= rq.func;
        req_bus.block_lo <= rq.block_lo;
        req_bus.block_hi <= rq.block_hi;
        req_bus.tweak_lo <= rq.tweak_lo;
        req_bus.tweak_hi <= rq.tweak_hi;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain();
        @(negedge i_clk);
        req_bus.valid <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge i_clk);
    endtask

    // Key register writes, one per cycle, plus one write to an unused index
    task automatic load_keys(input logic [63:0] k2lo, input logic [63:0] k2hi,
                             input logic [63:0] k3lo, input logic [63:0] k3hi,
                             input logic [63:0] mark);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_TK2_LO;
        cfg_data <= k2lo;
        @(negedge i_clk);
        cfg_idx  <= CFG_TK2_HI;
        cfg_data <= k2hi;
        @(negedge i_clk);
        cfg_idx  <= CFG_TK3_LO;
        cfg_data <= k3lo;
        @(negedge i_clk);
        cfg_idx  <= CFG_TK3_HI;
        cfg_data <= k3hi;
        @(negedge i_clk);
        cfg_idx  <= CFG_MARKER;
        cfg_data <= mark;
        @(negedge i_clk);
        cfg_idx  <= CFG_IDX_W'($urandom_range(CFG_IDX_LAST, CFG_MARKER + 1));
        cfg_data <= {$urandom, $urandom};
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // Main sequence
    initial begin
        t_cipher_req  rq;
        t_cipher_req  prev_rq;
        logic [127:0] prev_out;
        bit           have_prev;

        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = CFG_TK2_LO;
        cfg_data         = '0;
        req_bus.valid    = 1'b0;
        req_bus.func     = FUNC_ENC;
        req_bus.block_lo = '0;
        req_bus.block_hi = '0;
        req_bus.tweak_lo = '0;
        req_bus.tweak_hi = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats under the reset schedule
        for (int i = 0; i < NUM_DIRECTED; i++) send_req(directed_reqs[i]);
        drain();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       load_keys(ONES64, ONES64, ONES64, ONES64, ONES64);
                1:       load_keys(ZERO64, ZERO64, ZERO64, ZERO64, ~LSB64);
                default: load_keys(pick_word(), pick_word(), pick_word(), pick_word(),
                                   {$urandom, $urandom});
            endcase
            idling_on = (phase != NUM_PHASES - 1);
            if (phase == 2 || phase == 5) hold_req = 1'b1;
            have_prev = 1'b0;
            for (int n = 0; n < PHASE_BEATS; n++) begin
                // Mostly fresh blocks; some undo the previous beat with the same tweak
                if (have_prev && $urandom_range(0, 3) == 0) begin
                    rq.func     = ~prev_rq.func;
                    rq.block_lo = prev_out[63:0];
                    rq.block_hi = prev_out[127:64];
                    rq.tweak_lo = prev_rq.tweak_lo;
                    rq.tweak_hi = prev_rq.tweak_hi;
                end else begin
                    rq.func     = $urandom_range(0, 1) ? FUNC_DEC : FUNC_ENC;
                    rq.block_lo = pick_word();
                    rq.block_hi = pick_word();
                    rq.tweak_lo = pick_word();
                    rq.tweak_hi = pick_word();
                end
                prev_rq   = rq;
                prev_out  = cipher_block(rq.func, {rq.block_hi, rq.block_lo},
                                         {rq.tweak_hi, rq.tweak_lo});
                have_prev = 1'b1;
                send_req(rq);
            end
            drain();
        end

        // Catch any stray result beats
        repeat (NR + 8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_blocks.size() == 0) begin
            $display("** skinny128_384_tweakable_block_cipher: PASSED **");
        end else begin
            $display("** skinny128_384_tweakable_block_cipher: FAILED **");
        end
        $finish;
    end

endmodule

[files.f]
rtl/skn_pkg.sv
rtl/skn_req_if.sv
rtl/skn_rsp_if.sv
rtl/skn_round.sv
rtl/skn_key_sched.sv
rtl/skinny128_384_tweakable_block_cipher.sv
tb/tb.sv
